// ===== rtl/core/extended_euclid_bezout_core_defines.svh =====
// assertion macros for the extended euclid bezout core
`ifndef EXTENDED_EUCLID_BEZOUT_CORE_DEFINES_SVH
`define EXTENDED_EUCLID_BEZOUT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked property, disabled while reset is active
`define EEB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// clocked implication, disabled while reset is active
`define EEB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define EEB_ASSERT(lbl, clk, rstn, prop)
`define EEB_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/eeb_pkg.sv =====
// shared types for the extended euclid bezout core
`default_nettype none

package eeb_pkg;

  // control for one step of the shared divide and accumulate unit
  typedef struct packed {
    logic clear_acc;  // first quotient bit of a round
    logic dvd_bit;    // next dividend bit, msb first
  } eeb_step_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/eeb_req_if.sv =====
// request channel carrying the two operands
`default_nettype none

interface eeb_req_if #(
  parameter int DATA_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [DATA_BITS-2:0]   operand_a;
  logic [DATA_BITS-2:0]   operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/eeb_rsp_if.sv =====
// response channel carrying coefficients and gcd
`default_nettype none

interface eeb_rsp_if #(
  parameter int DATA_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_BITS-1:0]  coef_x;
  logic signed [DATA_BITS-1:0]  coef_y;
  logic        [DATA_BITS-2:0]  divisor_gcd;

  modport source (output valid, output coef_x, output coef_y, output divisor_gcd,
                  input ready);
  modport sink   (input valid, input coef_x, input coef_y, input divisor_gcd,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/eeb_step_unit.sv =====
// shared restoring divide step with horner accumulation of quotient times coefficient
`default_nettype none

module eeb_step_unit #(
  parameter int DATA_BITS = 32
) (
  input  eeb_pkg::eeb_step_ctrl_t  ctrl_i,
  input  logic [DATA_BITS-2:0]     rem_i,
  input  logic [DATA_BITS-2:0]     dvsr_i,
  input  logic [DATA_BITS-1:0]     xc_i,
  input  logic [DATA_BITS-1:0]     yc_i,
  input  logic [DATA_BITS-1:0]     tx_i,
  input  logic [DATA_BITS-1:0]     ty_i,
  output logic [DATA_BITS-2:0]     rem_o,
  output logic [DATA_BITS-1:0]     tx_o,
  output logic [DATA_BITS-1:0]     ty_o
);
  import eeb_pkg::*;

  localparam int OperW = DATA_BITS - 1;

  logic [OperW:0]   trial;
  logic [OperW+1:0] diff;
  logic             qbit;
  logic [DATA_BITS-1:0] tx_base;
  logic [DATA_BITS-1:0] ty_base;

  // remainder stays below the divisor, so the trial fits one extra bit
  assign trial = {rem_i, ctrl_i.dvd_bit};
  assign diff  = {1'b0, trial} - {2'b00, dvsr_i};
  assign qbit  = ~diff[OperW+1];
  assign rem_o = qbit ? diff[OperW-1:0] : trial[OperW-1:0];

  // t = 2t + qbit * c, modulo 2^DATA_BITS
  assign tx_base = ctrl_i.clear_acc ? '0 : {tx_i[DATA_BITS-2:0], 1'b0};
  assign ty_base = ctrl_i.clear_acc ? '0 : {ty_i[DATA_BITS-2:0], 1'b0};
  assign tx_o    = tx_base + (qbit ? xc_i : '0);
  assign ty_o    = ty_base + (qbit ? yc_i : '0);

endmodule

`default_nettype wire

// ===== rtl/core/extended_euclid_bezout_core.sv =====
// top level of the extended euclid bezout core: sequencer, round registers, result register
`default_nettype none

// Computes gcd(a,b) and Bezout coefficients x, y with a*x + b*y = gcd(a,b) for
// two unsigned DATA_BITS-1 bit operands; x and y come out as DATA_BITS bit two's
// complement. When b is zero the result is x=1, y=0, gcd=a. The block takes one
// request at a time: request ready is high only while the sequencer is idle. A
// request runs R Euclid division rounds (zero when b is zero, at most about 45
// for 31 bit operands). Each round steps through the dividend bits msb first in
// one shared restoring divide step, which also builds quotient times the current
// coefficients bit by bit, and then rotates remainders and coefficients. Results
// sit in an output register, so a new request is taken while a finished result
// still waits to be collected.

`include "extended_euclid_bezout_core_defines.svh"

module extended_euclid_bezout_core #(
  parameter int DATA_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  eeb_req_if.sink           req_i,
  eeb_rsp_if.source         rsp_o
);
  import eeb_pkg::*;

  localparam int OperW = DATA_BITS - 1;
  localparam int CntW  = $clog2(OperW);
  localparam logic [CntW-1:0] CntLast = CntW'(OperW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            rsp_valid_q;

  // remainder sequence: prev is the dividend, cur the divisor of the round
  logic [OperW-1:0]     prev_q, cur_q, rem_q, dvd_q;
  // coefficient pairs, kept modulo 2^DATA_BITS
  logic [DATA_BITS-1:0] xp_q, xc_q, yp_q, yc_q;
  // running quotient times current coefficient
  logic [DATA_BITS-1:0] tx_q, ty_q;
  // result register
  logic [DATA_BITS-1:0] coef_x_q, coef_y_q;
  logic [OperW-1:0]     gcd_q;

  logic [OperW-1:0]     rem_nx;
  logic [DATA_BITS-1:0] tx_nx, ty_nx;
  eeb_step_ctrl_t       step_ctrl;
  logic                 req_fire;
  logic                 out_free;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;
  // result register can take a new result this cycle
  assign out_free    = ~rsp_valid_q | rsp_o.ready;

  assign step_ctrl.clear_acc = (cnt_q == '0);
  assign step_ctrl.dvd_bit   = dvd_q[OperW-1];

  eeb_step_unit #(
    .DATA_BITS (DATA_BITS)
  ) u_step (
    .ctrl_i (step_ctrl),
    .rem_i  (rem_q),
    .dvsr_i (cur_q),
    .xc_i   (xc_q),
    .yc_i   (yc_q),
    .tx_i   (tx_q),
    .ty_i   (ty_q),
    .rem_o  (rem_nx),
    .tx_o   (tx_nx),
    .ty_o   (ty_nx)
  );

  // sequencer and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (req_fire) begin
            // b of zero skips all division rounds
            state_q <= (req_i.operand_b == '0) ? ST_FINISH : ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          cnt_q   <= '0;
          // a zero remainder ends the sequence
          state_q <= (rem_q == '0) ? ST_FINISH : ST_DIV;
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if ((state_q == ST_FINISH) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          prev_q <= req_i.operand_a;
          cur_q  <= req_i.operand_b;
          xp_q   <= DATA_BITS'(1);
          xc_q   <= '0;
          yp_q   <= '0;
          yc_q   <= DATA_BITS'(1);
          rem_q  <= '0;
          dvd_q  <= req_i.operand_a;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, msb first
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[OperW-2:0], 1'b0};
        tx_q  <= tx_nx;
        ty_q  <= ty_nx;
      end
      ST_UPDATE: begin
        // shift the remainder sequence and coefficient pairs by one round
        prev_q <= cur_q;
        cur_q  <= rem_q;
        xp_q   <= xc_q;
        xc_q   <= xp_q - tx_q;
        yp_q   <= yc_q;
        yc_q   <= yp_q - ty_q;
        rem_q  <= '0;
        dvd_q  <= cur_q;
      end
      ST_FINISH: begin
        if (out_free) begin
          coef_x_q <= xp_q;
          coef_y_q <= yp_q;
          gcd_q    <= prev_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.coef_x      = $signed(coef_x_q);
  assign rsp_o.coef_y      = $signed(coef_y_q);
  assign rsp_o.divisor_gcd = gcd_q;

  // divide rounds only run with a non-zero divisor
  `EEB_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == ST_DIV, cur_q != '0)
  // partial remainder stays below the divisor
  `EEB_ASSERT_IMPL(a_rem_below, clk_i, rst_ni, state_q == ST_DIV, rem_q < cur_q)
  // step counter never passes the last dividend bit
  `EEB_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, state_q == ST_DIV, cnt_q <= CntLast)
  // a new result only appears out of the finish step
  `EEB_ASSERT_IMPL(a_rsp_src, clk_i, rst_ni, $rose(rsp_valid_q), $past(state_q == ST_FINISH))
  // bezout coefficients are never both zero
  `EEB_ASSERT_IMPL(a_coef_nz, clk_i, rst_ni, rsp_valid_q, coef_x_q != '0 || coef_y_q != '0)

endmodule

`default_nettype wire

// ===== bench/extended_euclid_bezout_core_test.sv =====
// self-checking testbench for the extended euclid bezout core
`default_nettype none

module extended_euclid_bezout_core_test;

  localparam int DATA_BITS = 32;
  localparam int OPER_BITS = DATA_BITS - 1;
  localparam logic [OPER_BITS-1:0] OPER_MAX = '1;

  // slowest correct run: ~1600 requests of up to the longest length plus gaps and stalls,
  // taken about four times over, plus the long receiver hold-off
  localparam int CYCLE_LIMIT = 12_000_000;
  // covers the longest single request, of up to 45 division rounds
  localparam int DRAIN_CYCLES = 1500;
  localparam int MAX_REPORTS = 10;

  // expected contents of one response
  typedef struct packed {
    logic signed [DATA_BITS-1:0] coef_x;
    logic signed [DATA_BITS-1:0] coef_y;
    logic        [OPER_BITS-1:0] divisor_gcd;
  } bezout_t;

  logic clk_i;
  logic rst_ni;

  eeb_req_if #(.DATA_BITS(DATA_BITS)) req_if ();
  eeb_rsp_if #(.DATA_BITS(DATA_BITS)) rsp_if ();

  extended_euclid_bezout_core #(
    .DATA_BITS(DATA_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // results still owed by the block, oldest first
  bezout_t pending_bezout[$];

  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;
  int cycle_count;

  // clock; the single reset at the start of the run comes from the main stimulus block
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gcd and Bezout coefficients by the plain remainder sequence;
  // 64 bit intermediates keep every coefficient exact
  function automatic bezout_t predict_bezout(input logic [OPER_BITS-1:0] a,
                                             input logic [OPER_BITS-1:0] b);
    longint rem_prev, rem_cur, rem_next, quot;
    longint x_prev, x_cur, x_next, y_prev, y_cur, y_next;
    bezout_t res;
    rem_prev = longint'(a);
    rem_cur  = longint'(b);
    x_prev = 1;
    x_cur  = 0;
    y_prev = 0;
    y_cur  = 1;
    while (rem_cur != 0) begin
      quot     = rem_prev / rem_cur;
      rem_next = rem_prev % rem_cur;
      x_next   = x_prev - x_cur * quot;
      y_next   = y_prev - y_cur * quot;
      rem_prev = rem_cur;
      rem_cur  = rem_next;
      x_prev   = x_cur;
      x_cur    = x_next;
      y_prev   = y_cur;
      y_cur    = y_next;
    end
    // b of zero falls straight through: x=1, y=0, gcd=a
    res.coef_x      = DATA_BITS'(x_prev);
    res.coef_y      = DATA_BITS'(y_prev);
    res.divisor_gcd = OPER_BITS'(rem_prev);
    return res;
  endfunction

  function automatic logic [OPER_BITS-1:0] fib_term(input int k);
    longint f_lo, f_hi, f_nx;
    f_lo = 0;
    f_hi = 1;
    for (int i = 0; i < k; i++) begin
      f_nx = f_lo + f_hi;
      f_lo = f_hi;
      f_hi = f_nx;
    end
    return OPER_BITS'(f_lo);
  endfunction

  // operand with a spread of magnitudes: zero, max, full width, narrow
  function automatic logic [OPER_BITS-1:0] pick_operand();
    logic [OPER_BITS-1:0] val;
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = OPER_MAX;
      2, 3, 4, 5: val = OPER_BITS'($urandom);
      default: val = OPER_BITS'($urandom >> $urandom_range(30, 1));
    endcase
    return val;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // drive one request; entered and left at a falling edge
  task automatic send_operands(input logic [OPER_BITS-1:0] a,
                               input logic [OPER_BITS-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      // idle cycle with junk on the payload
      req_if.valid     = 1'b0;
      req_if.operand_a = OPER_BITS'($urandom);
      req_if.operand_b = OPER_BITS'($urandom);
      @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.operand_a = a;
    req_if.operand_b = b;
    do @(posedge clk_i); while (!req_if.ready);
    pending_bezout.insert(pending_bezout.size(), predict_bezout(a, b));
    @(negedge clk_i);
  endtask

  // response side: random stalls, or a long hold-off when one is requested
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        rsp_if.ready  = 1'b0;
        hold_off_left = hold_off_left - 1;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare every accepted response with the oldest owed result
  always @(posedge clk_i) begin : check_results
    bezout_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_bezout.size() == 0) begin
        report_error($sformatf("unexpected response x=%0d y=%0d gcd=%0d",
                               rsp_if.coef_x, rsp_if.coef_y, rsp_if.divisor_gcd));
      end else begin
        want = pending_bezout.pop_front();
        if (rsp_if.coef_x !== want.coef_x || rsp_if.coef_y !== want.coef_y ||
            rsp_if.divisor_gcd !== want.divisor_gcd) begin
          report_error($sformatf(
            "mismatch: expected x=%0d y=%0d gcd=%0d, got x=%0d y=%0d gcd=%0d",
            want.coef_x, want.coef_y, want.divisor_gcd,
            rsp_if.coef_x, rsp_if.coef_y, rsp_if.divisor_gcd));
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("extended_euclid_bezout_core_test: done, errors");
    $finish;
  end

  // zeros, extremes, swapped roles and the longest remainder sequence
  task automatic test_corner_operands();
    send_operands('0, '0);
    send_operands('0, 1);
    send_operands('0, OPER_MAX);
    send_operands(5, '0);
    send_operands(OPER_MAX, '0);
    send_operands(OPER_MAX, OPER_MAX);
    send_operands(OPER_MAX, 1);
    send_operands(1, OPER_MAX);
    send_operands(1, 1);
    send_operands(12, 18);
    send_operands(240, 46);
    send_operands(fib_term(46), fib_term(45));
    send_operands(fib_term(45), fib_term(46));
    send_operands(OPER_MAX, OPER_MAX - OPER_BITS'(1));
    send_operands(OPER_BITS'(1) << 30, OPER_BITS'(1) << 29);
    send_operands(OPER_BITS'(32'h5555_5555), OPER_BITS'(32'h2aaa_aaaa));
    send_operands(OPER_BITS'(1) << 30, 3);
    send_operands(OPER_MAX, OPER_BITS'(1) << 30);
    send_operands(OPER_BITS'(2147483629), OPER_BITS'(2147483587));
    send_operands(1000, 999);
  endtask

  task automatic test_random_operands(input int count);
    for (int i = 0; i < count; i++) send_operands(pick_operand(), pick_operand());
  endtask

  // operands sharing a random factor, so the gcd is usually not just one
  task automatic test_shared_factor(input int count);
    int unsigned factor, m, n;
    for (int i = 0; i < count; i++) begin
      factor = $urandom_range(1000, 1);
      m = $urandom_range(2_000_000);
      n = $urandom_range(2_000_000);
      send_operands(OPER_BITS'(factor * m), OPER_BITS'(factor * n));
    end
  endtask

  // neighboring fibonacci numbers give the most division rounds
  task automatic test_longest_sequences(input int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(45, 2);
      if ($urandom_range(1)) send_operands(fib_term(k + 1), fib_term(k));
      else send_operands(fib_term(k), fib_term(k + 1));
    end
  endtask

  // hold the response side off long enough for the core and its output
  // register to fill, so request ready has to drop
  task automatic test_output_hold_off();
    hold_off_left = 4000;
    for (int i = 0; i < 12; i++)
      send_operands(OPER_BITS'($urandom_range(100_000)), OPER_BITS'($urandom_range(100_000)));
  endtask

  initial begin
    error_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_left    = 0;
    req_if.valid     = 1'b0;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rst_ni           = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_operands();

    // idling phases: none, sender only, receiver only, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      test_random_operands(250);
      test_shared_factor(120);
      test_longest_sequences(30);
      if (phase == 0) test_output_hold_off();
    end

    req_if.valid = 1'b0;
    while (pending_bezout.size() != 0) @(posedge clk_i);
    // anything arriving now is a stray response
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("extended_euclid_bezout_core_test: done, clean");
    end else begin
      $display("extended_euclid_bezout_core_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
